// ----- rtl/core/edma_pkg.sv -----
// Shared constants and types for the echo distance dual moving average block.
`timescale 1ns / 1ps
`default_nettype none

package edma_pkg;

   localparam int DATA_W          = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int SHORT_DEPTH_DEF = 8;
   localparam int LONG_DEPTH_DEF  = 64;

   localparam logic [DATA_W-1:0] INIT_FILL_Q8 = 16'd51200;
   localparam logic [18:0]       CONV_FACTOR  = 19'd287729;
   localparam logic [15:0]       CONV_ROUND   = 16'h8000;

   localparam logic [DATA_W-1:0] MIN_VALID_RESET = 16'd512;
   localparam logic [DATA_W-1:0] MAX_VALID_RESET = 16'd51200;
   localparam logic [DATA_W-1:0] FAR_SUB_RESET   = 16'd25600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VALID = 2'd0,
      CSR_MAX_VALID = 2'd1,
      CSR_FAR_SUB   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic issue;
      logic push;
      logic commit;
      logic out_load;
   } win_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/echo_distance_dual_moving_average.sv -----
// Top level: echo distance filter with short and long moving averages.
// Four register stages from item accept to result valid (convert, classify/read, sum update,
// average multiply into the output register). Throughput: one item per cycle while rsp_stall
// is low; each window memory is read once and written once per cycle.
// Stages collapse bubbles, so req_stall rises only when all four stages hold an item.
// Reset clears the stage valids, loads the threshold defaults and the 200 cm fill sums;
// window memories are not cleared, a per-window wrap flag substitutes the fill for unwritten entries.
`timescale 1ns / 1ps
`default_nettype none

module echo_distance_dual_moving_average import edma_pkg::*; #(
   parameter int SHORT_DEPTH = SHORT_DEPTH_DEF,
   parameter int LONG_DEPTH  = LONG_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [15:0]          req_echo_time_us,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_accepted,
   output logic      [DATA_W-1:0]    rsp_sample_q8,
   output logic      [DATA_W-1:0]    rsp_short_average_q8,
   output logic      [DATA_W-1:0]    rsp_long_average_q8,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data
);

   logic [DATA_W-1:0] min_ff, max_ff, sub_ff;
   logic              ld_a, ld_b, ld_c, ld_d;
   logic              a_v_ff;
   logic [DATA_W-1:0] a_dist;
   logic              a_acc;
   logic [DATA_W-1:0] a_sample;
   logic              b_v_ff, b_acc_ff;
   logic [DATA_W-1:0] b_sample_ff;
   logic              c_v_ff, c_acc_ff;
   logic [DATA_W-1:0] c_sample_ff;
   logic              d_v_ff, d_acc_ff;
   logic [DATA_W-1:0] d_sample_ff;
   win_ctl_type       win_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_VALID_RESET;
         max_ff <= MAX_VALID_RESET;
         sub_ff <= FAR_SUB_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_VALID: min_ff <= csr_data;
            CSR_MAX_VALID: max_ff <= csr_data;
            CSR_FAR_SUB:   sub_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage loads, bubbles collapse
   assign ld_d      = !d_v_ff || !rsp_stall;
   assign ld_c      = !c_v_ff || ld_d;
   assign ld_b      = !b_v_ff || ld_c;
   assign ld_a      = !a_v_ff || ld_b;
   assign req_stall = !ld_a;

   edma_convert u_convert (
      .clock        (clock),
      .load         (ld_a),
      .echo_time_us (req_echo_time_us),
      .dist_q8      (a_dist)
   );

   always_comb begin
      a_acc    = a_dist >= min_ff;
      a_sample = (a_acc && a_dist > max_ff) ? sub_ff : a_dist;
   end

   always_comb begin
      win_ctl.issue    = ld_b;
      win_ctl.push     = a_v_ff && a_acc;
      win_ctl.commit   = b_v_ff && b_acc_ff && ld_c;
      win_ctl.out_load = ld_d;
   end

   edma_window #(.DEPTH(SHORT_DEPTH)) u_short_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .wr_data    (b_sample_ff),
      .average_q8 (rsp_short_average_q8)
   );

   edma_window #(.DEPTH(LONG_DEPTH)) u_long_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .wr_data    (b_sample_ff),
      .average_q8 (rsp_long_average_q8)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (ld_a) begin
            a_v_ff <= req_valid;
         end
         if (ld_b) begin
            b_v_ff <= a_v_ff;
         end
         if (ld_c) begin
            c_v_ff <= b_v_ff;
         end
         if (ld_d) begin
            d_v_ff <= c_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_b) begin
         b_acc_ff    <= a_acc;
         b_sample_ff <= a_sample;
      end
      if (ld_c) begin
         c_acc_ff    <= b_acc_ff;
         c_sample_ff <= b_sample_ff;
      end
      if (ld_d) begin
         d_acc_ff    <= c_acc_ff;
         d_sample_ff <= c_sample_ff;
      end
   end

   assign rsp_valid     = d_v_ff;
   assign rsp_accepted  = d_acc_ff;
   assign rsp_sample_q8 = d_sample_ff;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_v_ff && b_v_ff && c_v_ff && d_v_ff))
      else $error("input stalled with a free pipeline stage");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      $past(d_v_ff && !rsp_stall) && !$past(c_v_ff) |-> !d_v_ff)
      else $error("result repeated after it was taken");

   a_item_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(a_v_ff) |-> $past(req_valid && !req_stall))
      else $error("item appeared in convert stage without an accept");

endmodule

`default_nettype wire

// ----- rtl/core/edma_convert.sv -----
// Echo time to Q8.8 centimetre conversion stage.
`timescale 1ns / 1ps
`default_nettype none

module edma_convert import edma_pkg::*; (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [15:0]       echo_time_us,
   output logic      [DATA_W-1:0] dist_q8
);

   logic [34:0]       prod;
   logic [18:0]       scaled;
   logic [DATA_W-1:0] dist_in;
   logic [DATA_W-1:0] dist_ff;

   always_comb begin
      prod    = 35'(echo_time_us) * 35'(CONV_FACTOR) + 35'(CONV_ROUND);
      scaled  = prod[34:16];
      dist_in = (|scaled[18:16]) ? {DATA_W{1'b1}} : scaled[15:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_q8 = dist_ff;

endmodule

`default_nettype wire

// ----- rtl/core/edma_window.sv -----
// Ring window memory with running sum and reciprocal-multiply average.
`timescale 1ns / 1ps
`default_nettype none

module edma_window import edma_pkg::*; #(
   parameter int DEPTH = SHORT_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire win_ctl_type       ctl,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] average_q8
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = DATA_W + AW;
   localparam int SH = SW + AW;
   localparam int PW = 2 * SW + 1;

   localparam logic [63:0]    RECIP_WIDE = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
   localparam logic [SW:0]    RECIP      = RECIP_WIDE[SW:0];
   localparam logic [SW-1:0]  SUM_INIT   = SW'(DEPTH * int'(INIT_FILL_Q8));
   localparam logic [AW-1:0]  LAST_POS   = AW'(DEPTH - 1);

   logic [DATA_W-1:0] win_ff [DEPTH];
   logic [AW-1:0]     pos_ff, pos_in;
   logic              wrapped_ff, wrapped_in;
   logic [AW-1:0]     addr_ff;
   logic              fill_ff;
   logic [DATA_W-1:0] rd_ff;
   logic [DATA_W-1:0] old_value;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [PW-1:0]     prod_ff;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (ctl.issue && ctl.push) begin
         if (pos_ff == LAST_POS) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end
   end

   // entries not yet written on the first pass hold the initial fill
   assign old_value = fill_ff ? rd_ff : INIT_FILL_Q8;

   always_comb begin
      sum_in = sum_ff;
      if (ctl.commit) begin
         sum_in = sum_ff - SW'(old_value) + SW'(wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= SUM_INIT;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         rd_ff   <= win_ff[pos_ff];
         addr_ff <= pos_ff;
         fill_ff <= wrapped_ff;
      end
      if (ctl.commit) begin
         win_ff[addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         prod_ff <= PW'(sum_ff) * PW'(RECIP);
      end
   end

   assign average_q8 = prod_ff[SH +: DATA_W];

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      ctl.issue && ctl.commit |-> pos_ff != addr_ff)
      else $error("window read and write hit the same entry");

   a_wrap_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(wrapped_ff) |-> pos_ff == '0)
      else $error("window wrap flag set away from position zero");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(wrapped_ff) |-> $past(reset))
      else $error("window wrap flag cleared without reset");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the echo distance filter: self-checking against a cycle-free predictor.
`timescale 1ns / 1ps

module tb;
   import edma_pkg::*;

   localparam int SHORT_DEPTH    = SHORT_DEPTH_DEF;
   localparam int LONG_DEPTH     = LONG_DEPTH_DEF;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 130;
   localparam int HOLD_ITEMS     = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic              accepted;
      logic [DATA_W-1:0] sample_q8;
      logic [DATA_W-1:0] short_average_q8;
      logic [DATA_W-1:0] long_average_q8;
   } filter_result_type;

   class echo_filter_tracker;
      logic [DATA_W-1:0] min_q8, max_q8, far_q8;
      logic [DATA_W-1:0] short_win [SHORT_DEPTH];
      logic [DATA_W-1:0] long_win [LONG_DEPTH];
      int unsigned       short_pos, long_pos, short_sum, long_sum;
      filter_result_type pending_results [$];
      int                errors;

      function new();
         min_q8 = MIN_VALID_RESET;
         max_q8 = MAX_VALID_RESET;
         far_q8 = FAR_SUB_RESET;
         foreach (short_win[i]) short_win[i] = INIT_FILL_Q8;
         foreach (long_win[i]) long_win[i] = INIT_FILL_Q8;
         short_pos = 0;
         long_pos  = 0;
         short_sum = SHORT_DEPTH * INIT_FILL_Q8;
         long_sum  = LONG_DEPTH * INIT_FILL_Q8;
         errors    = 0;
      endfunction

      function logic [DATA_W-1:0] echo_to_q8(logic [15:0] echo_us);
         longint unsigned scaled;
         scaled = echo_us;
         scaled = (scaled * CONV_FACTOR + CONV_ROUND) >> 16;
         return (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
      endfunction

      function void write_reg(csr_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            CSR_MIN_VALID: min_q8 = value;
            CSR_MAX_VALID: max_q8 = value;
            CSR_FAR_SUB:   far_q8 = value;
            default: ;
         endcase
      endfunction

      function void note_echo(logic [15:0] echo_us);
         logic [DATA_W-1:0] distance_q8;
         filter_result_type res;
         distance_q8   = echo_to_q8(echo_us);
         res.accepted  = (distance_q8 >= min_q8);
         res.sample_q8 = distance_q8;
         if (res.accepted) begin
            if (distance_q8 > max_q8) res.sample_q8 = far_q8;
            short_sum            = short_sum - short_win[short_pos] + res.sample_q8;
            short_win[short_pos] = res.sample_q8;
            short_pos            = (short_pos + 1) % SHORT_DEPTH;
            long_sum             = long_sum - long_win[long_pos] + res.sample_q8;
            long_win[long_pos]   = res.sample_q8;
            long_pos             = (long_pos + 1) % LONG_DEPTH;
         end
         res.short_average_q8 = DATA_W'(short_sum / SHORT_DEPTH);
         res.long_average_q8  = DATA_W'(long_sum / LONG_DEPTH);
         pending_results.push_back(res);
      endfunction

      function void compare_field(string field, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(filter_result_type got);
         filter_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual sample %0d",
                     $time, got.sample_q8);
            return;
         end
         want = pending_results.pop_front();
         compare_field("accepted", DATA_W'(want.accepted), DATA_W'(got.accepted));
         compare_field("sample_q8", want.sample_q8, got.sample_q8);
         compare_field("short_average_q8", want.short_average_q8, got.short_average_q8);
         compare_field("long_average_q8", want.long_average_q8, got.long_average_q8);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [15:0]       req_echo_time_us = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_accepted;
   logic [DATA_W-1:0] rsp_sample_q8;
   logic [DATA_W-1:0] rsp_short_average_q8;
   logic [DATA_W-1:0] rsp_long_average_q8;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_index_type     csr_index = CSR_MIN_VALID;
   logic [DATA_W-1:0] csr_data = '0;

   bit                hold_request = 1'b0;
   int                idle_cycles = 0;
   echo_filter_tracker sb = new();

   echo_distance_dual_moving_average i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_echo_time_us,
      .rsp_valid,
      .rsp_stall,
      .rsp_accepted,
      .rsp_sample_q8,
      .rsp_short_average_q8,
      .rsp_long_average_q8,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      bit busy;
      busy = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_echo(req_echo_time_us);
            busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_accepted, rsp_sample_q8, rsp_short_average_q8,
                             rsp_long_average_q8});
            busy = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            busy = 1'b1;
         end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : rsp_stall_gen
      int pct;
      int stretch;
      pct     = 0;
      stretch = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         if (stretch == 0) begin
            case ($urandom_range(0, 4))
               0, 1:    pct = 0;
               2:       pct = 20;
               3:       pct = 50;
               default: pct = 90;
            endcase
            stretch = $urandom_range(32, 256);
         end
         stretch--;
         rsp_stall <= ($urandom_range(1, 100) <= pct);
      end
   end

   task automatic send_echo(input logic [15:0] echo_us);
      req_valid        <= 1'b1;
      req_echo_time_us <= echo_us;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [DATA_W-1:0] min_v, max_v, far_v);
      csr_index_type     order [3];
      logic [DATA_W-1:0] values [3];
      order  = '{CSR_MIN_VALID, CSR_MAX_VALID, CSR_FAR_SUB};
      values = '{min_v, max_v, far_v};
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= order[i];
         csr_data  <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // echo time whose distance lands within a couple of steps of a threshold
   function automatic logic [15:0] echo_near_q8(logic [DATA_W-1:0] thr);
      longint unsigned t;
      int              v;
      t = thr;
      t = (t << 16) / CONV_FACTOR;
      v = int'(t) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [15:0] pick_echo();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(0, 15000));
         4:          return 16'($urandom_range(0, 65535));
         5:          return 16'($urandom_range(0, 300));
         6, 7:       return echo_near_q8(sb.min_q8);
         default:    return echo_near_q8(sb.max_q8);
      endcase
   endfunction

   initial begin : stimulus
      logic [15:0]       directed [11];
      logic [15:0]       edge_case [5];
      logic [DATA_W-1:0] lo, hi, sub, anchor;
      int                left, burst, gap;
      directed  = '{16'd0, 16'd1, 16'd116, 16'd117, 16'd11661, 16'd11662, 16'd14925,
                    16'd14926, 16'hFFFF, 16'h5555, 16'hAAAA};
      edge_case = '{16'd3000, 16'd2999, 16'd9000, 16'd9001, 16'd20000};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_echo(directed[i]);
      wait_drained();

      // thresholds hit exactly, substitute below the reject level
      anchor = sb.echo_to_q8(16'd3000);
      write_regs(anchor, sb.echo_to_q8(16'd9000), anchor - 16'd1);
      foreach (edge_case[i]) send_echo(edge_case[i]);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase % 6)
            0: begin
               lo  = 16'($urandom_range(0, 20000));
               hi  = 16'($urandom_range(lo, 65535));
               sub = 16'($urandom_range(0, 65535));
            end
            1: begin
               if (phase < 6) begin
                  lo  = 16'd0;
                  hi  = 16'hFFFF;
                  sub = 16'd0;
               end else begin
                  lo  = 16'($urandom_range(0, 65535));
                  hi  = 16'($urandom_range(0, 65535));
                  sub = 16'($urandom_range(0, 65535));
               end
            end
            2: begin
               lo  = 16'hFFFF;
               hi  = 16'hFFFF;
               sub = 16'hFFFF;
            end
            3: begin
               lo  = 16'($urandom_range(0, 4000));
               hi  = 16'($urandom_range(lo, 65535));
               sub = 16'($urandom_range(0, 65535));
            end
            4: begin
               lo  = 16'd0;
               hi  = 16'd0;
               sub = 16'hFFFF;
            end
            default: begin
               lo  = 16'($urandom_range(2000, 10000));
               hi  = 16'($urandom_range(20000, 50000));
               sub = 16'($urandom_range(0, lo - 1));
            end
         endcase
         write_regs(lo, hi, sub);

         left = PHASE_ITEMS;
         if (phase == 3) begin
            hold_request = 1'b1;
            repeat (HOLD_ITEMS) send_echo(pick_echo());
            left -= HOLD_ITEMS;
         end
         while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_echo(pick_echo());
            left -= burst;
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 29) == 0) begin
               wait_drained();
            end else if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
